@@ rtl/tcsw_pkg.sv @@
// Shared types, constants and helpers for the text console scroll writer.
// No dependencies; used by tcsw_ctrl and text_console_scroll_writer.
package tcsw_pkg;

    // Screen geometry
    localparam int ROWS    = 25;
    localparam int COLUMNS = 80;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    // Field widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PRINT  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    // Request word
    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_column;
    } t_req;

    // Result word
    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_column;
    } t_rsp;

    // Character store access from the controller
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    // Linear store address of a cell
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

@@ rtl/tcsw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tcsw_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/tcsw_ctrl.sv @@
// Console sequencer: cursor registers and the clear / scroll / fill / print / read
// walks over the character store. Depends on tcsw_pkg.
module tcsw_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  tcsw_pkg::t_req            i_req,
    output logic                      o_strobe,
    output tcsw_pkg::t_rsp            o_rsp,
    output tcsw_pkg::t_mem_req        o_mem,
    input  logic [tcsw_pkg::CHAR_W-1:0] i_rd_data
);

    // Sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCROLL = 3'd2;
    localparam logic [2:0] ST_PRINT  = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;

    localparam int ADDR_W = tcsw_pkg::ADDR_W;
    localparam int CNT_W  = tcsw_pkg::CNT_W;
    localparam int ROW_W  = tcsw_pkg::ROW_W;
    localparam int COL_W  = tcsw_pkg::COL_W;
    localparam int CHAR_W = tcsw_pkg::CHAR_W;

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CHAR_W-1:0] r_char, n_char;
    logic              r_clr_report, n_clr_report;
    logic              r_scroll_post, n_scroll_post;
    logic              r_rd_ok, n_rd_ok;
    logic              r_strobe, n_strobe;
    tcsw_pkg::t_rsp    r_rsp, n_rsp;

    logic [CHAR_W-1:0] n_cell;
    logic              req_in_range;

    assign req_in_range = (i_req.read_row < ROW_W'(tcsw_pkg::ROWS)) &&
                          (i_req.read_column < COL_W'(tcsw_pkg::COLUMNS));

    // Next-state and store access logic
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_row         = r_row;
        n_col         = r_col;
        n_char        = r_char;
        n_clr_report  = r_clr_report;
        n_scroll_post = r_scroll_post;
        n_rd_ok       = r_rd_ok;
        n_strobe      = 1'b0;
        n_cell        = '0;
        o_mem.we      = 1'b0;
        o_mem.wr_addr = '0;
        o_mem.wr_data = '0;
        // scroll source: one row below the cell written next cycle
        o_mem.rd_addr = (r_cnt < CNT_W'(tcsw_pkg::CELLS - tcsw_pkg::COLUMNS)) ?
                        ADDR_W'(r_cnt + CNT_W'(tcsw_pkg::COLUMNS)) : '0;

        unique case (r_state)
            ST_CLEAR: begin
                o_mem.we      = 1'b1;
                o_mem.wr_addr = r_cnt[ADDR_W-1:0];
                if (r_cnt == CNT_W'(tcsw_pkg::CELLS - 1)) begin
                    n_state  = ST_IDLE;
                    n_strobe = r_clr_report;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_mem.rd_addr = req_in_range ?
                    tcsw_pkg::cell_addr(i_req.read_row, i_req.read_column) : '0;
                if (start) begin
                    unique case (i_req.req_type)
                        tcsw_pkg::REQ_PRINT: begin
                            n_char = i_req.char_code;
                            if (r_row >= ROW_W'(tcsw_pkg::ROWS)) begin
                                n_cnt         = '0;
                                n_scroll_post = 1'b0;
                                n_state       = ST_SCROLL;
                            end else begin
                                n_state = ST_PRINT;
                            end
                        end
                        tcsw_pkg::REQ_CLEAR: begin
                            n_row        = '0;
                            n_col        = '0;
                            n_cnt        = '0;
                            n_clr_report = 1'b1;
                            n_state      = ST_CLEAR;
                        end
                        tcsw_pkg::REQ_READ: begin
                            n_rd_ok = req_in_range;
                            n_state = ST_READ;
                        end
                        tcsw_pkg::REQ_UNUSED: begin
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCROLL: begin
                // write cell cnt-1 with the data read in the previous cycle, or zero for the last row
                if (r_cnt != '0) begin
                    o_mem.we      = 1'b1;
                    o_mem.wr_addr = ADDR_W'(r_cnt - 1'b1);
                    o_mem.wr_data = (r_cnt <= CNT_W'(tcsw_pkg::CELLS - tcsw_pkg::COLUMNS)) ?
                                    i_rd_data : '0;
                end
                if (r_cnt == CNT_W'(tcsw_pkg::CELLS)) begin
                    n_row = r_row - 1'b1;
                    if (r_scroll_post) begin
                        n_state  = ST_IDLE;
                        n_strobe = 1'b1;
                    end else begin
                        n_state = ST_PRINT;
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_PRINT: begin
                if (r_char == tcsw_pkg::NEWLINE_CODE) begin
                    n_state = ST_FILL;
                end else begin
                    o_mem.we      = 1'b1;
                    o_mem.wr_addr = tcsw_pkg::cell_addr(r_row, r_col);
                    o_mem.wr_data = r_char;
                    if (r_col == COL_W'(tcsw_pkg::COLUMNS - 1)) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                        if (r_row == ROW_W'(tcsw_pkg::ROWS - 1)) begin
                            n_cnt         = '0;
                            n_scroll_post = 1'b1;
                            n_state       = ST_SCROLL;
                        end else begin
                            n_state  = ST_IDLE;
                            n_strobe = 1'b1;
                        end
                    end else begin
                        n_col    = r_col + 1'b1;
                        n_state  = ST_IDLE;
                        n_strobe = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                // spaces to the end of the row
                o_mem.we      = 1'b1;
                o_mem.wr_addr = tcsw_pkg::cell_addr(r_row, r_col);
                o_mem.wr_data = tcsw_pkg::SPACE_CODE;
                if (r_col == COL_W'(tcsw_pkg::COLUMNS - 1)) begin
                    n_col    = '0;
                    n_row    = r_row + 1'b1;
                    n_state  = ST_IDLE;
                    n_strobe = 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            ST_READ: begin
                n_cell   = r_rd_ok ? i_rd_data : '0;
                n_state  = ST_IDLE;
                n_strobe = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        n_rsp.cell_char     = n_cell;
        n_rsp.cursor_row    = n_row;
        n_rsp.cursor_column = n_col;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_cnt         <= '0;
            r_row         <= ROW_W'(1);
            r_col         <= COL_W'(1);
            r_clr_report  <= 1'b0;
            r_scroll_post <= 1'b0;
            r_strobe      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_row         <= n_row;
            r_col         <= n_col;
            r_clr_report  <= n_clr_report;
            r_scroll_post <= n_scroll_post;
            r_strobe      <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_rd_ok <= n_rd_ok;
        if (n_strobe) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

@@ rtl/text_console_scroll_writer.sv @@
// Top level of the text console scroll writer: sequencer plus character store RAM.
// Depends on tcsw_pkg, tcsw_ctrl and tcsw_ram.

// Teletype console over a 25 x 80 character store held in one synchronous RAM with
// one write and one registered read port. A request word is taken when start is high
// and busy is low; exactly one result word follows, shown for one cycle with
// o_strobe, and it cannot be held off. Timing is set by the store's single write
// port, which moves one cell per cycle. An unused code is answered from idle; a
// read or a plain print makes a single store access; a newline also writes spaces
// to the end of its row; a clear and a scroll each rewrite every cell. A print
// scrolls at most once, either before the write (cursor parked below the last row by
// a newline) or after it (a write wrapping off the last row), so the longest print
// is a newline that scrolls first.
// After reset the store is cleared in a pass over every cell with busy high.
module text_console_scroll_writer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tcsw_pkg::t_req i_req,
    output logic           o_strobe,
    output tcsw_pkg::t_rsp o_rsp
);

    tcsw_pkg::t_mem_req                mem;
    logic [tcsw_pkg::CHAR_W-1:0]       rd_data;

    // Sequencer
    tcsw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_req     (i_req),
        .o_strobe  (o_strobe),
        .o_rsp     (o_rsp),
        .o_mem     (mem),
        .i_rd_data (rd_data)
    );

    // Character store
    tcsw_ram #(
        .WIDTH (tcsw_pkg::CHAR_W),
        .DEPTH (tcsw_pkg::CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (mem.we),
        .i_wr_addr (mem.wr_addr),
        .i_wr_data (mem.wr_data),
        .i_rd_addr (mem.rd_addr),
        .o_rd_data (rd_data)
    );

    // Writes stay inside the screen
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem.we |-> (mem.wr_addr < tcsw_pkg::ADDR_W'(tcsw_pkg::CELLS)))
        else $error("store write beyond last cell");

    // An accepted word either keeps the block busy or answers at once
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted word dropped");

    // Reported cursor stays on the screen (row may sit one past the bottom)
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_rsp.cursor_column < tcsw_pkg::COL_W'(tcsw_pkg::COLUMNS)) &&
                      (o_rsp.cursor_row <= tcsw_pkg::ROW_W'(tcsw_pkg::ROWS))))
        else $error("cursor out of range");

    // No word is taken while the store is being rewritten
    a_no_write_idle_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> !mem.we)
        else $error("store write while idle");

endmodule
